// File: src/md5_pkg.sv
package md5_pkg;

    // Initial chaining value words A, B, C and D.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // Padding marker byte and block geometry.
    localparam logic [7:0] PAD_MARKER  = 8'h80;
    localparam int         BLOCK_WORDS = 16;
    localparam logic [3:0] LAST_WORD   = 4'd15;
    localparam logic [3:0] LEN_WORD_M1 = 4'd13;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    // Default depth of the word queue between front and back.
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    // One 32-bit message word on its way to the compression engine.
    typedef struct packed {
        logic        final_word;
        logic [31:0] word;
    } word_item_t;

    // Front sequencer states.
    typedef enum logic [2:0] {
        FRONT_IDLE,
        FRONT_PAD_FIRST,
        FRONT_PAD_ZERO,
        FRONT_LEN_LO,
        FRONT_LEN_HI
    } front_state_t;

    // Compression engine states.
    typedef enum logic [1:0] {
        CORE_LOAD,
        CORE_ROUND,
        CORE_FINISH
    } core_state_t;

    // Additive round constant of each of the 64 rounds.
    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotate amount: four per quarter, picked by the round's low two bits.
    function automatic logic [4:0] shift_amt(input logic [5:0] idx);
        logic [4:0] s;
        unique case ({idx[5:4], idx[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// File: src/md5_front.sv
module md5_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                last,
    output logic                push,
    output md5_pkg::word_item_t push_item,
    input  logic                queue_full
);

    md5_pkg::front_state_t state_reg, state_next;
    logic [63:0] msg_bits_reg, msg_bits_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  widx_reg, widx_next;
    logic        extra_reg, extra_next;

    logic [5:0]  fill;
    logic [1:0]  lane;
    logic [31:0] merged;
    logic [31:0] pad_word;
    logic [3:0]  first_widx;
    logic        first_extra;
    logic        accept;

    assign fill        = msg_bits_reg[8:3];
    assign lane        = fill[1:0];
    assign first_widx  = fill[5:2];
    assign first_extra = (fill[5:3] == 3'b111);
    assign accept      = in_valid && in_ready;

    // Incoming byte dropped into its lane of the partial word.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            merged[8*k +: 8] = (2'(k) == lane) ? data_byte : word_reg[8*k +: 8];
        end
    end

    // First padding word: held bytes, the marker, then zeros.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (2'(k) < lane) begin
                pad_word[8*k +: 8] = word_reg[8*k +: 8];
            end else if (2'(k) == lane) begin
                pad_word[8*k +: 8] = md5_pkg::PAD_MARKER;
            end else begin
                pad_word[8*k +: 8] = 8'h00;
            end
        end
    end

    // Next-state logic of the padding sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            md5_pkg::FRONT_IDLE: begin
                if (accept && last) begin
                    state_next = md5_pkg::FRONT_PAD_FIRST;
                end
            end
            md5_pkg::FRONT_PAD_FIRST: begin
                if (!queue_full) begin
                    if (first_widx == md5_pkg::LEN_WORD_M1 && !first_extra) begin
                        state_next = md5_pkg::FRONT_LEN_LO;
                    end else begin
                        state_next = md5_pkg::FRONT_PAD_ZERO;
                    end
                end
            end
            md5_pkg::FRONT_PAD_ZERO: begin
                if (!queue_full && widx_reg == md5_pkg::LEN_WORD_M1 && !extra_reg) begin
                    state_next = md5_pkg::FRONT_LEN_LO;
                end
            end
            md5_pkg::FRONT_LEN_LO: begin
                if (!queue_full) begin
                    state_next = md5_pkg::FRONT_LEN_HI;
                end
            end
            md5_pkg::FRONT_LEN_HI: begin
                if (!queue_full) begin
                    state_next = md5_pkg::FRONT_IDLE;
                end
            end
            default: state_next = md5_pkg::FRONT_IDLE;
        endcase
    end

    // Handshake, pushed words and datapath updates per state.
    always_comb begin
        in_ready      = 1'b0;
        push          = 1'b0;
        push_item     = '0;
        msg_bits_next = msg_bits_reg;
        word_next     = word_reg;
        widx_next     = widx_reg;
        extra_next    = extra_reg;
        unique case (state_reg)
            md5_pkg::FRONT_IDLE: begin
                in_ready = !queue_full;
                if (accept && has_byte) begin
                    word_next     = merged;
                    msg_bits_next = msg_bits_reg + 64'd8;
                    if (lane == 2'd3) begin
                        push           = 1'b1;
                        push_item.word = merged;
                    end
                end
            end
            md5_pkg::FRONT_PAD_FIRST: begin
                push_item.word = pad_word;
                if (!queue_full) begin
                    push       = 1'b1;
                    widx_next  = first_widx + 4'd1;
                    extra_next = first_extra && (first_widx != md5_pkg::LAST_WORD);
                end
            end
            md5_pkg::FRONT_PAD_ZERO: begin
                if (!queue_full) begin
                    push       = 1'b1;
                    widx_next  = widx_reg + 4'd1;
                    extra_next = extra_reg && (widx_reg != md5_pkg::LAST_WORD);
                end
            end
            md5_pkg::FRONT_LEN_LO: begin
                push_item.word = msg_bits_reg[31:0];
                push           = !queue_full;
            end
            md5_pkg::FRONT_LEN_HI: begin
                push_item.word       = msg_bits_reg[63:32];
                push_item.final_word = 1'b1;
                if (!queue_full) begin
                    push          = 1'b1;
                    msg_bits_next = '0;
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // Control state and length counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= md5_pkg::FRONT_IDLE;
            msg_bits_reg <= '0;
            widx_reg     <= '0;
            extra_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            msg_bits_reg <= msg_bits_next;
            widx_reg     <= widx_next;
            extra_reg    <= extra_next;
        end
    end

    // Partial word under assembly.
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

endmodule

// File: src/md5_queue.sv
module md5_queue #(
    parameter int DEPTH = md5_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  md5_pkg::word_item_t push_item,
    output logic                full,
    input  logic                pop,
    output md5_pkg::word_item_t pop_item,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    md5_pkg::word_item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/md5_core.sv
module md5_core (
    input  logic                aclk,
    input  logic                aresetn,
    output logic                pop,
    input  md5_pkg::word_item_t pop_item,
    input  logic                empty,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         digest_word,
    output logic                upper_half,
    output logic                final_part
);

    md5_pkg::core_state_t state_reg, state_next;

    logic [31:0]  w_reg [md5_pkg::BLOCK_WORDS];
    logic [3:0]   cnt_reg;
    logic [5:0]   round_reg;
    logic         final_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [127:0] digest_reg;
    logic         out_valid_reg, out_half_reg;

    logic         load_word, start_rounds, finish_block, emit_digest;
    logic [3:0]   r4, g;
    logic [31:0]  f, sum, rot;
    logic [63:0]  dbl;
    logic [4:0]   sh;
    logic [31:0]  sum_a, sum_b, sum_c, sum_d;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            md5_pkg::CORE_LOAD: begin
                if (!empty && cnt_reg == md5_pkg::LAST_WORD) begin
                    state_next = md5_pkg::CORE_ROUND;
                end
            end
            md5_pkg::CORE_ROUND: begin
                if (round_reg == md5_pkg::LAST_ROUND) begin
                    state_next = md5_pkg::CORE_FINISH;
                end
            end
            md5_pkg::CORE_FINISH: begin
                if (!final_reg || !out_valid_reg) begin
                    state_next = md5_pkg::CORE_LOAD;
                end
            end
            default: state_next = md5_pkg::CORE_LOAD;
        endcase
    end

    // Control outputs per state.
    always_comb begin
        load_word    = 1'b0;
        start_rounds = 1'b0;
        finish_block = 1'b0;
        emit_digest  = 1'b0;
        unique case (state_reg)
            md5_pkg::CORE_LOAD: begin
                load_word    = !empty;
                start_rounds = !empty && (cnt_reg == md5_pkg::LAST_WORD);
            end
            md5_pkg::CORE_ROUND: begin
                load_word = 1'b0;
            end
            md5_pkg::CORE_FINISH: begin
                finish_block = !final_reg;
                emit_digest  = final_reg && !out_valid_reg;
            end
            default: begin
                load_word = 1'b0;
            end
        endcase
    end

    assign pop = load_word;

    // Round function, message word index and rotation of one round.
    assign r4 = round_reg[3:0];
    always_comb begin
        unique case (round_reg[5:4])
            2'd0: begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = r4;
            end
            2'd1: begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = (r4 << 2) + r4 + 4'd1;
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = (r4 << 1) + r4 + 4'd5;
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = (r4 << 3) - r4;
            end
        endcase
    end

    assign sum = f + a_reg + md5_pkg::round_const(round_reg) + w_reg[g];
    assign sh  = md5_pkg::shift_amt(round_reg);
    assign dbl = {sum, sum} << sh;
    assign rot = dbl[63:32];

    // Block result folded into the chaining value.
    assign sum_a = ch_a_reg + a_reg;
    assign sum_b = ch_b_reg + b_reg;
    assign sum_c = ch_c_reg + c_reg;
    assign sum_d = ch_d_reg + d_reg;

    // Control registers and chaining value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= md5_pkg::CORE_LOAD;
            cnt_reg       <= '0;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_half_reg  <= 1'b0;
            ch_a_reg      <= md5_pkg::IV_A;
            ch_b_reg      <= md5_pkg::IV_B;
            ch_c_reg      <= md5_pkg::IV_C;
            ch_d_reg      <= md5_pkg::IV_D;
        end else begin
            state_reg <= state_next;
            if (load_word) begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (start_rounds) begin
                final_reg <= pop_item.final_word;
                round_reg <= '0;
            end else if (state_reg == md5_pkg::CORE_ROUND) begin
                round_reg <= round_reg + 6'd1;
            end
            if (finish_block) begin
                ch_a_reg <= sum_a;
                ch_b_reg <= sum_b;
                ch_c_reg <= sum_c;
                ch_d_reg <= sum_d;
            end else if (emit_digest) begin
                ch_a_reg <= md5_pkg::IV_A;
                ch_b_reg <= md5_pkg::IV_B;
                ch_c_reg <= md5_pkg::IV_C;
                ch_d_reg <= md5_pkg::IV_D;
            end
            // Output register: lower half first, then upper half.
            if (emit_digest) begin
                out_valid_reg <= 1'b1;
                out_half_reg  <= 1'b0;
            end else if (out_valid_reg && out_ready) begin
                if (out_half_reg) begin
                    out_valid_reg <= 1'b0;
                end
                out_half_reg <= 1'b1;
            end
        end
    end

    // Message words, working variables and the held digest.
    always_ff @(posedge aclk) begin
        if (load_word) begin
            w_reg[cnt_reg] <= pop_item.word;
        end
        if (start_rounds) begin
            a_reg <= ch_a_reg;
            b_reg <= ch_b_reg;
            c_reg <= ch_c_reg;
            d_reg <= ch_d_reg;
        end else if (state_reg == md5_pkg::CORE_ROUND) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
        if (emit_digest) begin
            digest_reg <= {sum_d, sum_c, sum_b, sum_a};
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = out_half_reg ? digest_reg[127:64] : digest_reg[63:0];
    assign upper_half  = out_half_reg;
    assign final_part  = out_half_reg;

endmodule

// File: src/md5_stream_hash.sv
// MD5 digest over a byte stream.
// Input channel (s_axis_*): one transaction per step. tdata[7:0] is the message
// byte, tuser says the byte is present, tlast ends the message. A transaction
// with tuser low and tlast high finishes the message with no further byte, so
// an empty message is possible; tuser and tlast both low is an idle step.
// Output channel (m_axis_*): two transactions per message, digest bytes 0-7
// first (tuser low), then bytes 8-15 (tuser high, tlast high).
// A front sequencer packs bytes into 32-bit words and generates the padding;
// a word queue feeds the compression engine, which runs one round per cycle.
// In steady streaming the block rate is set by the rounds, the finish step and
// the word loads, with the queue depth bounding how far the front runs ahead.
// Input is accepted one byte per cycle until the queue fills. After tlast the
// front stalls input while it pushes padding words, longer while the queue is
// full; the first digest half appears once the engine has finished the last
// block.
// Reset clears the message length, the queue and the output register, and loads
// the initial chaining value. If the receiver stalls, the digest stays in the
// output register, and the engine holds a following digest until the register
// is free, which in turn backs up the input.
module md5_stream_hash #(
    parameter int QUEUE_DEPTH = md5_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic        m_axis_tuser,   // [0] upper_half
    output logic        m_axis_tlast
);

    md5_pkg::word_item_t push_item, pop_item;
    logic push, pop, queue_full, queue_empty;

    // Byte packing and padding.
    md5_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .has_byte   (s_axis_tuser),
        .last       (s_axis_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // Word queue between front and engine.
    md5_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    // Compression engine and output register.
    md5_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop         (pop),
        .pop_item    (pop_item),
        .empty       (queue_empty),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .digest_word (m_axis_tdata),
        .upper_half  (m_axis_tuser),
        .final_part  (m_axis_tlast)
    );

endmodule

// File: src/md5_checker.sv
module md5_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // The output register is empty right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Only the upper digest half closes the run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
        else $error("tlast does not match the digest half");

    // The upper half follows the lower half in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tuser)
        |=> (m_axis_tvalid && m_axis_tuser))
        else $error("upper digest half missing");

    // A stalled result holds its valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled result holds its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind md5_stream_hash md5_checker u_md5_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
